/* rtl/core/gcc_pkg.sv */
// Shared types and constants for the curve smoothing and curvature unit.
`default_nettype none
package gcc_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_TAPS   = 512;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int CW         = PT_AW + 1;
  localparam int JW         = $clog2(MAX_POINTS + MAX_TAPS) + 1;
  localparam int ACC_W      = 40 + TAP_AW;
  localparam int LMAX       = (MAX_TAPS - 1) / 2;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;

  localparam logic [CFG_IW-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HALF_TAPS   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_OPEN_CURVE  = 2'd2;

  localparam logic [1:0] OP_LOAD_TAP = 2'd0;
  localparam logic [1:0] OP_LOAD_PT  = 2'd1;
  localparam logic [1:0] OP_EVAL     = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [8:0]          item_index;
    logic signed [15:0]  coord_x;
    logic signed [15:0]  coord_y;
    logic signed [23:0]  gauss_tap;
    logic signed [23:0]  slope_tap;
    logic signed [23:0]  bend_tap;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  smooth_x;
    logic signed [15:0]  smooth_y;
    logic signed [31:0]  curvature;
    logic                degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pt_word_t;

  typedef struct packed {
    logic signed [23:0] g;
    logic signed [23:0] s;
    logic signed [23:0] b;
  } tap_word_t;

  typedef struct packed {
    logic              pt_we;
    logic              tap_we;
    logic [PT_AW-1:0]  pt_addr;
    logic [TAP_AW-1:0] tap_addr;
  } mem_req_t;

endpackage
`default_nettype wire

/* rtl/core/gcc_mem.sv */
// Point store and kernel tap store, one port each, registered read.
`default_nettype none
module gcc_mem (
  input  logic                clk,
  input  gcc_pkg::mem_req_t   mem_req,
  input  gcc_pkg::in_item_t   wr_item,
  output gcc_pkg::pt_word_t   pt_rd_r,
  output gcc_pkg::tap_word_t  tap_rd_r
);
  import gcc_pkg::*;

  pt_word_t  pt_mem  [MAX_POINTS];
  tap_word_t tap_mem [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (mem_req.pt_we) begin
      pt_mem[mem_req.pt_addr] <= {wr_item.coord_x, wr_item.coord_y};
    end
    pt_rd_r <= pt_mem[mem_req.pt_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_req.tap_we) begin
      tap_mem[mem_req.tap_addr] <= {wr_item.gauss_tap, wr_item.slope_tap, wr_item.bend_tap};
    end
    tap_rd_r <= tap_mem[mem_req.tap_addr];
  end

endmodule
`default_nettype wire

/* rtl/core/gcc_mul.sv */
// Shared signed multiplier with registered product.
`default_nettype none
module gcc_mul (
  input  logic               clk,
  input  logic signed [32:0] mul_a,
  input  logic signed [32:0] mul_b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

/* rtl/core/gaussian_curve_curvature_unit.sv */
// Top level: sequencer, accumulators, bit-serial root and divider.
`default_nettype none
// Load items (tap triple or point) give an all-zero result.
// An evaluate item runs as follows: each of the 2L+1 taps takes a read and
// six products on the single shared multiplier; then four products build
// X^2+Y^2 and the numerator, a 48-step bit-serial square root, four partial
// products for the denominator and a 31-step restoring divider finish the
// curvature. A zero derivative skips the root and the divider, a saturated
// curvature skips the divider. On a closed curve the start index is reduced
// by repeated subtraction of the point count before the taps are read.
// in_stall is high for the whole evaluation.
module gaussian_curve_curvature_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gcc_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gcc_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [gcc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gcc_pkg::CFG_DW-1:0]  cfg_data
);
  import gcc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MAC   = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_RND   = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DEN   = 4'd9;
  localparam logic [3:0] S_OVF   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_SGN   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [3:0] T_GX    = 4'd0;
  localparam logic [3:0] T_GY    = 4'd1;
  localparam logic [3:0] T_DX    = 4'd2;
  localparam logic [3:0] T_DY    = 4'd3;
  localparam logic [3:0] T_DDX   = 4'd4;
  localparam logic [3:0] T_DDY   = 4'd5;
  localparam logic [3:0] T_SQ    = 4'd6;
  localparam logic [3:0] T_NUMP  = 4'd7;
  localparam logic [3:0] T_NUMM  = 4'd8;
  localparam logic [3:0] T_DEN0  = 4'd9;
  localparam logic [3:0] T_DEN32 = 4'd10;
  localparam logic [3:0] T_DEN64 = 4'd11;

  localparam int DEN_W = 112;
  localparam logic [5:0] SQ_LAST  = 6'd47;
  localparam logic [5:0] DIV_LAST = 6'd30;

  localparam logic signed [ACC_W:0] SM_HALF  = (ACC_W+1)'(1 << 19);
  localparam logic signed [ACC_W:0] SM_MAX   = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0] SM_MIN   = (ACC_W+1)'(-32768);
  localparam logic signed [ACC_W:0] DER_HALF = (ACC_W+1)'(1 << 15);
  localparam logic signed [ACC_W:0] DER_MAX  = (ACC_W+1)'(2147483647);
  localparam logic signed [ACC_W:0] DER_MIN  = (ACC_W+1)'(-2147483647);

  function automatic logic signed [15:0] rnd_smooth(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] t;
    t = signed'({v[ACC_W-1], v}) + SM_HALF;
    t = t >>> 20;
    if (t > SM_MAX) return SM_MAX[15:0];
    if (t < SM_MIN) return SM_MIN[15:0];
    return t[15:0];
  endfunction

  function automatic logic signed [31:0] rnd_der(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] t;
    t = signed'({v[ACC_W-1], v}) + DER_HALF;
    t = t >>> 16;
    if (t > DER_MAX) return DER_MAX[31:0];
    if (t < DER_MIN) return DER_MIN[31:0];
    return t[31:0];
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [8:0]  point_count_r;
  logic [7:0]  half_taps_r;
  logic        open_curve_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [2:0]  ph_r;
  logic [5:0]  it_r;
  logic        mv_r;
  logic [3:0]  tag_r;

  logic [CW-1:0]            cnt_eff;
  logic [TAP_AW-1:0]        l_eff, lq_r, t_r;
  logic signed [JW-1:0]     j_r, cnt_s, last_s, pt_sel;
  logic signed [ACC_W-1:0]  acc_gx_r, acc_gy_r, acc_dx_r, acc_dy_r, acc_ddx_r, acc_ddy_r;
  logic signed [15:0]       sm_x_r, sm_y_r;
  logic signed [31:0]       dx_r, dy_r, ddx_r, ddy_r;
  logic [63:0]              s_r, mag_r;
  logic signed [63:0]       num_r;
  logic                     neg_r;
  logic [95:0]              vsh_r;
  logic [47:0]              root_r;
  logic [51:0]              srem_r, srem2, strial;
  logic                     sge;
  logic [DEN_W-1:0]         den_r, prem_r, prem0;
  logic [DEN_W:0]           dtrial, dden;
  logic                     dge, ovf;
  logic [30:0]              q_r;
  logic signed [31:0]       res_curv_r;
  logic                     res_deg_r;

  logic        acc, acc_eval, eval_ok, slot_free, out_load;
  mem_req_t    mem_req;
  pt_word_t    pt_rd_r;
  tap_word_t   tap_rd_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic        mul_go;
  logic [3:0]  mul_tag;

  gcc_mem u_mem (
    .clk      (clk),
    .mem_req  (mem_req),
    .wr_item  (in_item),
    .pt_rd_r  (pt_rd_r),
    .tap_rd_r (tap_rd_r)
  );

  gcc_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    if (point_count_r == '0) begin
      cnt_eff = CW'(1);
    end else if (32'(point_count_r) > MAX_POINTS) begin
      cnt_eff = CW'(MAX_POINTS);
    end else begin
      cnt_eff = CW'(point_count_r);
    end
    if (32'(half_taps_r) > LMAX) begin
      l_eff = TAP_AW'(LMAX);
    end else begin
      l_eff = TAP_AW'(half_taps_r);
    end
  end

  assign cnt_s  = signed'(JW'(cnt_eff));
  assign last_s = cnt_s - JW'(1);

  // clamp on an open curve; a closed curve keeps the wrapped index
  always_comb begin
    if (!open_curve_r) begin
      pt_sel = j_r;
    end else if (j_r < 0) begin
      pt_sel = '0;
    end else if (j_r > last_s) begin
      pt_sel = last_s;
    end else begin
      pt_sel = j_r;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign acc       = in_valid && !in_stall;
  assign eval_ok   = 32'(in_item.item_index) < 32'(cnt_eff);
  assign acc_eval  = acc && (in_item.opcode == OP_EVAL) && eval_ok;
  assign out_load  = (acc && !acc_eval) || ((state_r == S_FIN) && slot_free);

  always_comb begin
    mem_req.pt_we  = acc && (in_item.opcode == OP_LOAD_PT) &&
                     (32'(in_item.item_index) < MAX_POINTS);
    mem_req.tap_we = acc && (in_item.opcode == OP_LOAD_TAP) &&
                     (32'(in_item.item_index) < MAX_TAPS);
    if (state_r == S_IDLE) begin
      mem_req.pt_addr  = PT_AW'(in_item.item_index);
      mem_req.tap_addr = TAP_AW'(in_item.item_index);
    end else begin
      mem_req.pt_addr  = PT_AW'(pt_sel);
      mem_req.tap_addr = t_r;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_tag = T_GX;
    mul_go  = 1'b0;
    case (state_r)
      S_MAC: begin
        mul_go = 1'b1;
        case (ph_r)
          3'd0: begin mul_a = 33'(pt_rd_r.x); mul_b = 33'(tap_rd_r.g); mul_tag = T_GX;  end
          3'd1: begin mul_a = 33'(pt_rd_r.y); mul_b = 33'(tap_rd_r.g); mul_tag = T_GY;  end
          3'd2: begin mul_a = 33'(pt_rd_r.x); mul_b = 33'(tap_rd_r.s); mul_tag = T_DX;  end
          3'd3: begin mul_a = 33'(pt_rd_r.y); mul_b = 33'(tap_rd_r.s); mul_tag = T_DY;  end
          3'd4: begin mul_a = 33'(pt_rd_r.x); mul_b = 33'(tap_rd_r.b); mul_tag = T_DDX; end
          3'd5: begin mul_a = 33'(pt_rd_r.y); mul_b = 33'(tap_rd_r.b); mul_tag = T_DDY; end
          default: mul_go = 1'b0;
        endcase
      end
      S_SQ: begin
        mul_go = (ph_r < 3'd4);
        case (ph_r)
          3'd0: begin mul_a = 33'(dx_r);  mul_b = 33'(dx_r);  mul_tag = T_SQ;   end
          3'd1: begin mul_a = 33'(dy_r);  mul_b = 33'(dy_r);  mul_tag = T_SQ;   end
          3'd2: begin mul_a = 33'(dx_r);  mul_b = 33'(ddy_r); mul_tag = T_NUMP; end
          3'd3: begin mul_a = 33'(ddx_r); mul_b = 33'(dy_r);  mul_tag = T_NUMM; end
          default: mul_go = 1'b0;
        endcase
      end
      S_DEN: begin
        mul_go = (ph_r < 3'd4);
        case (ph_r)
          3'd0: begin
            mul_a = signed'({1'b0, s_r[31:0]});  mul_b = signed'({1'b0, root_r[31:0]});
            mul_tag = T_DEN0;
          end
          3'd1: begin
            mul_a = signed'({1'b0, s_r[31:0]});  mul_b = signed'(33'(root_r[47:32]));
            mul_tag = T_DEN32;
          end
          3'd2: begin
            mul_a = signed'({1'b0, s_r[63:32]}); mul_b = signed'({1'b0, root_r[31:0]});
            mul_tag = T_DEN32;
          end
          3'd3: begin
            mul_a = signed'({1'b0, s_r[63:32]}); mul_b = signed'(33'(root_r[47:32]));
            mul_tag = T_DEN64;
          end
          default: mul_go = 1'b0;
        endcase
      end
      default: mul_go = 1'b0;
    endcase
  end

  // root step: bring down two radicand bits, try (4r+1)
  assign srem2  = {srem_r[49:0], vsh_r[95:94]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sge    = srem2 >= strial;

  // divider step: numerator bits below the first quotient bit are zero
  assign prem0  = DEN_W'(mag_r) << 17;
  assign ovf    = prem0 >= den_r;
  assign dtrial = {prem_r, 1'b0};
  assign dden   = {1'b0, den_r};
  assign dge    = dtrial >= dden;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc_eval) state_nxt = S_WRAP;
      S_WRAP:  if (open_curve_r || (j_r < cnt_s)) state_nxt = S_RD;
      S_RD:    state_nxt = S_MAC;
      S_MAC:   if (ph_r == 3'd5) state_nxt = (t_r == (lq_r << 1)) ? S_DRAIN : S_RD;
      S_DRAIN: state_nxt = S_RND;
      S_RND:   state_nxt = S_SQ;
      S_SQ:    if (ph_r == 3'd4) state_nxt = S_CHK;
      S_CHK:   state_nxt = (s_r == '0) ? S_FIN : S_SQRT;
      S_SQRT:  if (it_r == '0) state_nxt = S_DEN;
      S_DEN:   if (ph_r == 3'd4) state_nxt = S_OVF;
      S_OVF:   state_nxt = ovf ? S_FIN : S_DIV;
      S_DIV:   if (it_r == '0) state_nxt = S_SGN;
      S_SGN:   state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      mv_r          <= 1'b0;
      ph_r          <= '0;
      it_r          <= '0;
      point_count_r <= 9'd200;
      half_taps_r   <= 8'd5;
      open_curve_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mv_r    <= mul_go;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_MAC:          ph_r <= (ph_r == 3'd5) ? 3'd0 : ph_r + 3'd1;
        S_SQ, S_DEN:    ph_r <= (ph_r == 3'd4) ? 3'd0 : ph_r + 3'd1;
        default:        ph_r <= '0;
      endcase
      case (state_r)
        S_CHK:          it_r <= SQ_LAST;
        S_OVF:          it_r <= DIV_LAST;
        S_SQRT, S_DIV:  it_r <= it_r - 6'd1;
        default:        it_r <= it_r;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: point_count_r <= cfg_data[8:0];
          REG_HALF_TAPS:   half_taps_r   <= cfg_data[7:0];
          REG_OPEN_CURVE:  open_curve_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= mul_tag;
    if (mv_r) begin
      case (tag_r)
        T_GX:    acc_gx_r  <= acc_gx_r  + ACC_W'(prod_r);
        T_GY:    acc_gy_r  <= acc_gy_r  + ACC_W'(prod_r);
        T_DX:    acc_dx_r  <= acc_dx_r  + ACC_W'(prod_r);
        T_DY:    acc_dy_r  <= acc_dy_r  + ACC_W'(prod_r);
        T_DDX:   acc_ddx_r <= acc_ddx_r + ACC_W'(prod_r);
        T_DDY:   acc_ddy_r <= acc_ddy_r + ACC_W'(prod_r);
        T_SQ:    s_r       <= s_r + prod_r[63:0];
        T_NUMP:  num_r     <= num_r + signed'(prod_r[63:0]);
        T_NUMM:  num_r     <= num_r - signed'(prod_r[63:0]);
        T_DEN0:  den_r     <= den_r + DEN_W'(prod_r[63:0]);
        T_DEN32: den_r     <= den_r + (DEN_W'(prod_r[63:0]) << 32);
        T_DEN64: den_r     <= den_r + (DEN_W'(prod_r[63:0]) << 64);
        default: ;
      endcase
    end
    case (state_r)
      S_IDLE: begin
        if (acc_eval) begin
          j_r       <= signed'(JW'(in_item.item_index)) + signed'(JW'(l_eff));
          lq_r      <= l_eff;
          t_r       <= '0;
          acc_gx_r  <= '0;
          acc_gy_r  <= '0;
          acc_dx_r  <= '0;
          acc_dy_r  <= '0;
          acc_ddx_r <= '0;
          acc_ddy_r <= '0;
        end
      end
      S_WRAP: begin
        if (!open_curve_r && (j_r >= cnt_s)) j_r <= j_r - cnt_s;
      end
      S_MAC: begin
        if ((ph_r == 3'd5) && (t_r != (lq_r << 1))) begin
          t_r <= t_r + TAP_AW'(1);
          if (!open_curve_r && (j_r == '0)) begin
            j_r <= last_s;
          end else begin
            j_r <= j_r - JW'(1);
          end
        end
      end
      S_RND: begin
        sm_x_r <= rnd_smooth(acc_gx_r);
        sm_y_r <= rnd_smooth(acc_gy_r);
        dx_r   <= rnd_der(acc_dx_r);
        dy_r   <= rnd_der(acc_dy_r);
        ddx_r  <= rnd_der(acc_ddx_r);
        ddy_r  <= rnd_der(acc_ddy_r);
        s_r    <= '0;
        num_r  <= '0;
      end
      S_CHK: begin
        if (s_r == '0) begin
          res_curv_r <= '0;
          res_deg_r  <= 1'b1;
        end else begin
          vsh_r  <= {s_r, 32'd0};
          root_r <= '0;
          srem_r <= '0;
          mag_r  <= num_r[63] ? (64'd0 - num_r) : num_r;
          neg_r  <= num_r[63];
        end
      end
      S_SQRT: begin
        vsh_r  <= vsh_r << 2;
        srem_r <= sge ? (srem2 - strial) : srem2;
        root_r <= {root_r[46:0], sge};
        if (it_r == '0) den_r <= '0;
      end
      S_OVF: begin
        if (ovf) begin
          res_curv_r <= neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          res_deg_r  <= 1'b1;
        end else begin
          prem_r <= prem0;
          q_r    <= '0;
        end
      end
      S_DIV: begin
        prem_r <= dge ? DEN_W'(dtrial - dden) : DEN_W'(dtrial);
        q_r    <= {q_r[29:0], dge};
      end
      S_SGN: begin
        res_curv_r <= neg_r ? signed'(32'd0 - {1'b0, q_r}) : signed'({1'b0, q_r});
        res_deg_r  <= 1'b0;
      end
      default: ;
    endcase
    if (acc && !acc_eval) begin
      out_item_r.smooth_x   <= '0;
      out_item_r.smooth_y   <= '0;
      out_item_r.curvature  <= '0;
      out_item_r.degenerate <= (in_item.opcode == OP_EVAL);
    end else if ((state_r == S_FIN) && slot_free) begin
      out_item_r.smooth_x   <= sm_x_r;
      out_item_r.smooth_y   <= sm_y_r;
      out_item_r.curvature  <= res_curv_r;
      out_item_r.degenerate <= res_deg_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_mac_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> ((pt_sel >= 0) && (pt_sel < cnt_s)))
    else $error("point address outside the curve during accumulation");

  a_mul_use: assert property (@(posedge clk) disable iff (!rst_n)
    mv_r |-> ((state_r == S_RD) || (state_r == S_MAC) || (state_r == S_DRAIN) ||
              (state_r == S_SQ) || (state_r == S_DEN)))
    else $error("multiplier product pending outside an accumulation phase");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (srem_r <= 52'({root_r, 1'b0})))
    else $error("root remainder exceeds bound");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (prem_r < den_r))
    else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire
